FILE: rtl/arp_cache_table_macros.svh
// ---------------------------------------------------------------------------
// arp_cache_table_macros.svh
// Assertion macros for the ARP cache table. The including module must have
// signals named clk and rst in scope.
// ---------------------------------------------------------------------------
`ifndef ARP_CACHE_TABLE_MACROS_SVH
`define ARP_CACHE_TABLE_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ARPC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be true outside reset.
`define ARPC_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: rtl/arpc_pkg.sv
// ---------------------------------------------------------------------------
// arpc_pkg
// Shared constants, operation codes and transaction types of the ARP cache.
// ---------------------------------------------------------------------------
package arpc_pkg;

  localparam int ENTRIES = 128;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam logic [CNT_W-1:0] ENTRIES_CNT = CNT_W'(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(ENTRIES - 1);

  localparam logic [1:0] MODE_REQUEST = 2'd0;
  localparam logic [1:0] MODE_REPLY   = 2'd1;
  localparam logic [1:0] MODE_LOOKUP  = 2'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] ip_addr;
    logic [47:0] mac_addr;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [47:0] mac_out;
    logic        status;
  } out_t;

  // Write and read controls from the sequencer to the entry store.
  typedef struct packed {
    logic             ip_we;
    logic             mac_we;
    logic [IDX_W-1:0] wr_addr;
    logic [31:0]      ip_data;
    logic [47:0]      mac_data;
    logic [IDX_W-1:0] rd_addr;
  } store_ctl_t;

endpackage

FILE: rtl/arp_cache_table.sv
// ---------------------------------------------------------------------------
// arp_cache_table
// Append-only IPv4-to-MAC cache with one pending slot, searched by a
// sequential scan of the entry store.
// ---------------------------------------------------------------------------
// Channel   Ports                 Direction  Transfer
// command   start, busy, cmd      in         start high while busy low
// result    done, result          out        done high for one cycle
//
// A request, a reply or an unused mode raises the result strobe in the cycle
// after acceptance. In a lookup the scan reads one slot per cycle through the
// store's registered read port and stops at the first zero IP, the first
// match or the last slot. The IP store needs no clearing pass; slots past the
// pending index read as zero. Reset is synchronous and active high. The
// receiver cannot stall, and busy stays high until the result strobe has gone.
// ---------------------------------------------------------------------------
`include "arp_cache_table_macros.svh"

module arp_cache_table (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  arpc_pkg::in_t  cmd,
  output logic           busy,
  output logic           done,
  output arpc_pkg::out_t result
);

  arpc_pkg::store_ctl_t ctl;
  logic [31:0]          rd_ip;
  logic [47:0]          rd_mac;

  arpc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result),
    .ctl    (ctl),
    .rd_ip  (rd_ip),
    .rd_mac (rd_mac)
  );

  arpc_store u_store (
    .clk    (clk),
    .ctl    (ctl),
    .rd_ip  (rd_ip),
    .rd_mac (rd_mac)
  );

  `ARPC_ASSERT(a_done_busy, done |-> busy, "result strobe outside a transaction")
  `ARPC_ASSERT(a_done_pulse, done |=> !done, "result strobe longer than one cycle")
  `ARPC_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted command not held busy")
  `ARPC_NEVER(a_found_full, done && result.found && result.status, "found with full status")

endmodule

FILE: rtl/arpc_store.sv
// ---------------------------------------------------------------------------
// arpc_store
// IP and MAC entry memories: one write port each, one shared read address,
// registered read data.
// ---------------------------------------------------------------------------
module arpc_store (
  input  logic                clk,
  input  arpc_pkg::store_ctl_t ctl,
  output logic [31:0]         rd_ip,
  output logic [47:0]         rd_mac
);

  logic [31:0] ip_mem  [arpc_pkg::ENTRIES];
  logic [47:0] mac_mem [arpc_pkg::ENTRIES];

  always_ff @(posedge clk) begin
    if (ctl.ip_we) begin
      ip_mem[ctl.wr_addr] <= ctl.ip_data;
    end
    rd_ip <= ip_mem[ctl.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.mac_we) begin
      mac_mem[ctl.wr_addr] <= ctl.mac_data;
    end
    rd_mac <= mac_mem[ctl.rd_addr];
  end

endmodule

FILE: rtl/arpc_ctrl.sv
// ---------------------------------------------------------------------------
// arpc_ctrl
// Command sequencer: handles request and reply writes and steps the lookup
// scan through the entry store with a single IP compare unit.
// ---------------------------------------------------------------------------
module arpc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  arpc_pkg::in_t        cmd,
  output logic                 busy,
  output logic                 done,
  output arpc_pkg::out_t       result,
  output arpc_pkg::store_ctl_t ctl,
  input  logic [31:0]          rd_ip,
  input  logic [47:0]          rd_mac
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  localparam int CNT_W = arpc_pkg::CNT_W;
  localparam int IDX_W = arpc_pkg::IDX_W;

  logic [1:0]       state, state_next;
  logic [CNT_W-1:0] pend, pend_next;
  logic             pend_written, pend_written_next;
  logic [CNT_W-1:0] rd_cnt, rd_cnt_next;
  logic             chk_valid, chk_valid_next;
  logic [IDX_W-1:0] chk_idx, chk_idx_next;
  logic [31:0]      key, key_next;
  arpc_pkg::out_t   res, res_next;

  logic             full;
  logic [CNT_W-1:0] chk_ext;
  logic             chk_live;
  logic [31:0]      ip_eff;

  assign full     = (pend == arpc_pkg::ENTRIES_CNT);
  assign chk_ext  = CNT_W'(chk_idx);
  // Slots above the pending index were never written since reset and read
  // as zero; the pending slot counts only once a request has filled it.
  assign chk_live = (chk_ext < pend) || ((chk_ext == pend) && pend_written);
  assign ip_eff   = chk_live ? rd_ip : 32'd0;

  always_comb begin
    state_next        = state;
    pend_next         = pend;
    pend_written_next = pend_written;
    rd_cnt_next       = rd_cnt;
    chk_valid_next    = chk_valid;
    chk_idx_next      = chk_idx;
    key_next          = key;
    res_next          = res;
    ctl               = '0;
    ctl.wr_addr       = pend[IDX_W-1:0];
    ctl.rd_addr       = rd_cnt[IDX_W-1:0];

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          key_next   = cmd.ip_addr;
          res_next   = '0;
          state_next = ST_RESP;
          unique case (cmd.mode)
            arpc_pkg::MODE_REQUEST: begin
              if (full) begin
                res_next.status = arpc_pkg::STATUS_FULL;
              end else begin
                ctl.ip_we         = 1'b1;
                ctl.ip_data       = cmd.ip_addr;
                pend_written_next = 1'b1;
              end
            end
            arpc_pkg::MODE_REPLY: begin
              if (full) begin
                res_next.status = arpc_pkg::STATUS_FULL;
              end else begin
                ctl.mac_we        = 1'b1;
                ctl.mac_data      = cmd.mac_addr;
                // A reply with no request leaves a zero IP behind it.
                ctl.ip_we         = !pend_written;
                ctl.ip_data       = 32'd0;
                pend_next         = pend + 1'b1;
                pend_written_next = 1'b0;
              end
            end
            arpc_pkg::MODE_LOOKUP: begin
              rd_cnt_next    = '0;
              chk_valid_next = 1'b0;
              state_next     = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        // Issue the next read while the previous slot is being compared.
        if (rd_cnt < arpc_pkg::ENTRIES_CNT) begin
          chk_valid_next = 1'b1;
          chk_idx_next   = rd_cnt[IDX_W-1:0];
          rd_cnt_next    = rd_cnt + 1'b1;
        end else begin
          chk_valid_next = 1'b0;
        end
        if (chk_valid) begin
          if (ip_eff == 32'd0) begin
            state_next = ST_RESP;
          end else if ((ip_eff == key) && (chk_ext != pend)) begin
            res_next.found   = 1'b1;
            res_next.mac_out = rd_mac;
            state_next       = ST_RESP;
          end else if (chk_idx == arpc_pkg::LAST_IDX) begin
            state_next = ST_RESP;
          end
        end
      end
      ST_RESP: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      pend         <= '0;
      pend_written <= 1'b0;
      chk_valid    <= 1'b0;
      rd_cnt       <= '0;
    end else begin
      state        <= state_next;
      pend         <= pend_next;
      pend_written <= pend_written_next;
      chk_valid    <= chk_valid_next;
      rd_cnt       <= rd_cnt_next;
    end
    chk_idx <= chk_idx_next;
    key     <= key_next;
    res     <= res_next;
  end

  assign busy   = (state != ST_IDLE);
  assign done   = (state == ST_RESP);
  assign result = res;

endmodule

FILE: dv/arp_cache_table_tb.sv
// ---------------------------------------------------------------------------
// arp_cache_table_tb
// Self-checking testbench for the ARP cache table. Commands go in through the
// start/busy handshake and a scoreboard class keeps its own copy of the cache
// to predict every result. A short directed sequence comes first, then random
// traffic that fills the whole table and keeps looking entries up once it is
// full, under three sender idle patterns.
// ---------------------------------------------------------------------------
module arp_cache_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  class arp_cache_scoreboard;
    logic [31:0]    ip_tab[arpc_pkg::ENTRIES];
    logic [47:0]    mac_tab[arpc_pkg::ENTRIES];
    int unsigned    next_slot;
    arpc_pkg::out_t due_results[$];
    int unsigned    errors;
    int unsigned    n_cmds;
    int unsigned    n_lookups;
    int unsigned    n_hits;
    int unsigned    n_rejected;

    function new();
      for (int k = 0; k < arpc_pkg::ENTRIES; k++) begin
        ip_tab[k]  = '0;
        mac_tab[k] = '0;
      end
      next_slot  = 0;
      errors     = 0;
      n_cmds     = 0;
      n_lookups  = 0;
      n_hits     = 0;
      n_rejected = 0;
    endfunction

    // Updates the cache copy for an accepted transaction and queues its result.
    function void record_command(arpc_pkg::in_t c);
      arpc_pkg::out_t want;
      bit             is_full;
      want    = '0;
      is_full = (next_slot >= arpc_pkg::ENTRIES);
      n_cmds++;
      case (c.mode)
        arpc_pkg::MODE_REQUEST: begin
          if (is_full) begin
            want.status = arpc_pkg::STATUS_FULL;
            n_rejected++;
          end else begin
            ip_tab[next_slot] = c.ip_addr;
          end
        end
        arpc_pkg::MODE_REPLY: begin
          if (is_full) begin
            want.status = arpc_pkg::STATUS_FULL;
            n_rejected++;
          end else begin
            mac_tab[next_slot] = c.mac_addr;
            next_slot++;
          end
        end
        arpc_pkg::MODE_LOOKUP: begin
          n_lookups++;
          // The scan ends at the first empty IP; the slot still waiting for
          // its reply never matches.
          for (int k = 0; k < arpc_pkg::ENTRIES && ip_tab[k] != '0 && !want.found;
               k++) begin
            if (ip_tab[k] == c.ip_addr && k != next_slot) begin
              want.found   = 1'b1;
              want.mac_out = mac_tab[k];
            end
          end
          if (want.found) n_hits++;
        end
        default: ;
      endcase
      due_results.push_back(want);
    endfunction

    function void check_response(arpc_pkg::out_t got);
      arpc_pkg::out_t want;
      if (due_results.size() == 0) begin
        $error("unexpected result: found=%0b mac_out=%h status=%0b",
               got.found, got.mac_out, got.status);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (got.found !== want.found) begin
        $error("found: expected %0b, actual %0b", want.found, got.found);
        errors++;
      end
      if (got.mac_out !== want.mac_out) begin
        $error("mac_out: expected %h, actual %h", want.mac_out, got.mac_out);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0b, actual %0b", want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           start = 1'b0;
  arpc_pkg::in_t  cmd = '0;
  logic           busy;
  logic           done;
  arpc_pkg::out_t result;

  arp_cache_scoreboard cache_sb;
  int unsigned         idle_pct;
  int unsigned         items_sent;

  arp_cache_table i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done) cache_sb.check_response(result);
      if (start && !busy) cache_sb.record_command(cmd);
    end
  end

  function automatic logic [31:0] any_ip();
    return $urandom;
  endfunction

  function automatic logic [31:0] any_ip_nz();
    logic [31:0] ip;
    ip = $urandom;
    if (ip == '0) ip = 32'd1;
    return ip;
  endfunction

  function automatic logic [47:0] any_mac();
    logic [47:0] mac;
    mac[31:0]  = $urandom;
    mac[47:32] = 16'($urandom_range(16'hFFFF));
    return mac;
  endfunction

  // IP of a completed slot, or a fresh one while the table is still empty.
  function automatic logic [31:0] known_ip();
    if (cache_sb.next_slot == 0) return any_ip_nz();
    return cache_sb.ip_tab[$urandom_range(cache_sb.next_slot - 1)];
  endfunction

  // Presents one transaction and holds it until the block takes it, then
  // lets the sender go quiet for a random stretch.
  task automatic issue(input logic [1:0] mode, input logic [31:0] ip,
                       input logic [47:0] mac);
    arpc_pkg::in_t c;
    c.mode     = mode;
    c.ip_addr  = ip;
    c.mac_addr = mac;
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    items_sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic run_directed();
    issue(arpc_pkg::MODE_LOOKUP, 32'h0A00_0001, '0);
    issue(arpc_pkg::MODE_LOOKUP, 32'h0, '1);
    issue(MODE_UNUSED, '1, '1);
    issue(arpc_pkg::MODE_REQUEST, 32'hFFFF_FFFF, '0);
    issue(arpc_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, '0);
    issue(arpc_pkg::MODE_REQUEST, 32'h8000_0001, '1);
    issue(arpc_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, '0);
    issue(arpc_pkg::MODE_REPLY, '0, 48'hFFFF_FFFF_FFFF);
    issue(arpc_pkg::MODE_LOOKUP, 32'h8000_0001, '0);
    issue(arpc_pkg::MODE_REQUEST, 32'h0000_0001, '0);
    issue(arpc_pkg::MODE_REPLY, '1, 48'h0);
    issue(arpc_pkg::MODE_LOOKUP, 32'h0000_0001, '1);
    // A second entry for the same IP; lookups must return the older one.
    issue(arpc_pkg::MODE_REQUEST, 32'h8000_0001, '0);
    issue(arpc_pkg::MODE_REPLY, '0, 48'h8000_0000_0001);
    issue(arpc_pkg::MODE_LOOKUP, 32'h8000_0001, '0);
    issue(arpc_pkg::MODE_REQUEST, 32'h7FFF_FFFF, '0);
    issue(arpc_pkg::MODE_LOOKUP, 32'h7FFF_FFFF, '0);
    issue(arpc_pkg::MODE_REPLY, '0, 48'h7FFF_FFFF_FFFF);
    issue(arpc_pkg::MODE_LOOKUP, 32'h7FFF_FFFF, '0);
    issue(arpc_pkg::MODE_LOOKUP, 32'h0, '0);
    issue(arpc_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, '1);
  endtask

  // The last slot first gets a real IP so that a scan can run over the whole
  // table, then is overwritten with a zero IP and completed, which leaves it
  // exactly as a reply without a request would.
  task automatic fill_last_slot();
    logic [31:0] ip;
    ip = any_ip_nz();
    issue(arpc_pkg::MODE_REQUEST, ip, any_mac());
    issue(arpc_pkg::MODE_LOOKUP, any_ip(), any_mac());
    issue(arpc_pkg::MODE_LOOKUP, ip, any_mac());
    issue(arpc_pkg::MODE_LOOKUP, known_ip(), any_mac());
    issue(arpc_pkg::MODE_REQUEST, 32'h0, any_mac());
    issue(arpc_pkg::MODE_LOOKUP, known_ip(), any_mac());
    issue(arpc_pkg::MODE_LOOKUP, any_ip(), any_mac());
    issue(arpc_pkg::MODE_REPLY, any_ip(), any_mac());
  endtask

  task automatic random_step();
    int unsigned roll;
    bit          is_full;
    logic [31:0] ip;
    roll    = $urandom_range(99);
    is_full = (cache_sb.next_slot >= arpc_pkg::ENTRIES);
    if (cache_sb.next_slot == arpc_pkg::ENTRIES - 1) begin
      fill_last_slot();
    end else if (roll < 16) begin
      if (is_full) begin
        issue(arpc_pkg::MODE_REQUEST, any_ip(), any_mac());
      end else begin
        ip = ($urandom_range(9) < 3) ? known_ip() : any_ip_nz();
        issue(arpc_pkg::MODE_REQUEST, ip, any_mac());
        issue(arpc_pkg::MODE_REPLY, any_ip(), any_mac());
      end
    end else if (roll < 22) begin
      // A stray request; the next completed pair overwrites it.
      issue(arpc_pkg::MODE_REQUEST, any_ip_nz(), any_mac());
    end else if (roll < 26 && is_full) begin
      issue(arpc_pkg::MODE_REPLY, any_ip(), any_mac());
    end else if (roll < 56) begin
      issue(arpc_pkg::MODE_LOOKUP, known_ip(), any_mac());
    end else if (roll < 68) begin
      issue(arpc_pkg::MODE_LOOKUP, any_ip(), any_mac());
    end else if (roll < 76) begin
      ip = is_full ? any_ip() : cache_sb.ip_tab[cache_sb.next_slot];
      issue(arpc_pkg::MODE_LOOKUP, ip, any_mac());
    end else if (roll < 84) begin
      issue(MODE_UNUSED, any_ip(), any_mac());
    end else if (roll < 88) begin
      issue(arpc_pkg::MODE_LOOKUP, 32'h0, any_mac());
    end else begin
      issue(arpc_pkg::MODE_LOOKUP, known_ip() ^ (32'd1 << $urandom_range(31)),
            any_mac());
    end
  endtask

  initial begin
    cache_sb   = new();
    items_sent = 0;
    idle_pct   = 37;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    while (items_sent < 570) random_step();
    idle_pct = 77;
    while (items_sent < 1110) random_step();
    idle_pct = 0;
    while (items_sent < 1650) random_step();
    start <= 1'b0;
    while (cache_sb.due_results.size() != 0) @(posedge clk);
    repeat (arpc_pkg::ENTRIES + 4) @(posedge clk);
    $display("Run covered %0d commands, %0d of them lookups with %0d hits.",
             cache_sb.n_cmds, cache_sb.n_lookups, cache_sb.n_hits);
    $display("Table filled %0d of %0d slots; %0d requests or replies refused as full.",
             cache_sb.next_slot, arpc_pkg::ENTRIES, cache_sb.n_rejected);
    if (cache_sb.errors == 0) begin
      $display("arp_cache_table_tb: PASS");
    end else begin
      $display("arp_cache_table_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("Timed out waiting for the block.");
    $display("arp_cache_table_tb: FAIL");
    $finish;
  end

endmodule
